// ===== rtl/bmprpd_pkg.sv =====
// bmprpd_pkg: shared types, codes and colour conversion for the BMP row pixel decoder.
// No dependencies; every other file refers to it by scoped names.
package bmprpd_pkg;

    localparam int COORD_W    = 12;
    localparam int COLOUR_W   = 24;
    localparam int IDX_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_PIXEL   = 1'b1;

    localparam logic [1:0] SRC_4BPP  = 2'd0;
    localparam logic [1:0] SRC_8BPP  = 2'd1;
    localparam logic [1:0] SRC_24BPP = 2'd2;

    localparam logic [1:0] OUT_332 = 2'd0;
    localparam logic [1:0] OUT_555 = 2'd1;
    localparam logic [1:0] OUT_565 = 2'd2;
    localparam logic [1:0] OUT_888 = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT    = 2'd3;

    typedef enum logic [1:0] {
        OP_PAL_WRITE,
        OP_PIX_PAL,
        OP_PIX_RGB
    } op_kind_t;

    typedef struct packed {
        op_kind_t             kind;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic                 last;
        logic [IDX_W-1:0]     idx;
        logic [COLOUR_W-1:0]  colour;
    } op_t;

    function automatic logic [COLOUR_W-1:0] convert_colour(
        input logic [1:0]          mode,
        input logic [COLOUR_W-1:0] c
    );
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = c[23:16];
        g = c[15:8];
        b = c[7:0];
        unique case (mode)
            OUT_332: convert_colour = {16'h0000, b[7:6], g[7:5], r[7:5]};
            OUT_555: convert_colour = {9'h000, r[7:3], g[7:3], b[7:3]};
            OUT_565: convert_colour = {8'h00, r[7:3], g[7:2], b[7:3]};
            default: convert_colour = c;
        endcase
    endfunction

endpackage

// ===== rtl/bmprpd_if.sv =====
// bmprpd_req_if / bmprpd_pix_if: valid/ready channels of the decoder.
// Depends on bmprpd_pkg for field widths.
interface bmprpd_req_if;
    logic                               valid;
    logic                               ready;
    logic                               req_type;
    logic [bmprpd_pkg::IDX_W-1:0]       palette_index;
    logic [bmprpd_pkg::COLOUR_W-1:0]    palette_value;
    logic [bmprpd_pkg::BYTE_W-1:0]      data_byte;

    modport source (output valid, req_type, palette_index, palette_value, data_byte,
                    input ready);
    modport sink   (input valid, req_type, palette_index, palette_value, data_byte,
                    output ready);
endinterface

interface bmprpd_pix_if;
    logic                               valid;
    logic                               ready;
    logic [bmprpd_pkg::COORD_W-1:0]     pixel_x;
    logic [bmprpd_pkg::COORD_W-1:0]     pixel_y;
    logic [bmprpd_pkg::COLOUR_W-1:0]    pixel_value;
    logic                               last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_value, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_value, last_pixel, output ready);
endinterface

// ===== rtl/bmprpd_front.sv =====
// bmprpd_front: config registers, row/column/byte counters, byte classification.
// Emits one op_t per cycle into the queue while op_ready is high. Depends on bmprpd_pkg, bmprpd_if.
module bmprpd_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    bmprpd_req_if.sink                          req,
    input  logic                                cfg_we,
    input  logic [bmprpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bmprpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                op_valid,
    output bmprpd_pkg::op_t                     op,
    input  logic                                op_ready,
    output logic [1:0]                          out_depth
);

    localparam int CDW  = bmprpd_pkg::CFG_DATA_W;
    localparam int CMAX = (1 << CDW) - 1;
    localparam int WMAX = (MAX_WIDTH < CMAX) ? MAX_WIDTH : CMAX;
    localparam int HMAX = (MAX_HEIGHT < CMAX) ? MAX_HEIGHT : CMAX;
    localparam int CW   = $clog2(WMAX + 1);
    localparam int HW   = $clog2(HMAX + 1);
    localparam int BW   = $clog2(3 * WMAX + 4);

    localparam logic [1:0] PH_BLUE  = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_RED   = 2'd2;

    logic [CW-1:0]  width_reg, width_next, w_wr;
    logic [HW-1:0]  height_reg, height_next, h_wr;
    logic [1:0]     depth_reg, depth_next, d_wr;
    logic [1:0]     out_depth_reg, out_depth_next;
    logic [BW-1:0]  data_bytes_reg, data_bytes_next;
    logic [BW-1:0]  row_size_reg, row_size_next;

    logic [BW-1:0]  row_byte_reg, row_byte_next, rb1;
    logic [CW-1:0]  col_reg, col_next, col1;
    logic [HW-1:0]  rows_reg, rows_next;
    logic [15:0]    partial_reg, partial_next;
    logic [1:0]     phase_reg, phase_next;
    logic           pend_valid_reg, pend_valid_next;
    bmprpd_pkg::op_t pend_op_reg, pend_op_next;

    logic            accept;
    logic            push_new;
    bmprpd_pkg::op_t new_op;
    logic            rows_last;
    logic            last0;
    logic            last1;
    logic            has_low;
    logic            in_data;
    logic [bmprpd_pkg::COORD_W-1:0] y_cur;

    assign req.ready = !pend_valid_reg && op_ready;
    assign accept    = req.valid && req.ready;
    assign out_depth = out_depth_reg;

    // config write path: clamp and precompute row geometry
    always_comb
    begin
        if (cfg_data == '0)
            w_wr = CW'(1);
        else if (cfg_data > CDW'(WMAX))
            w_wr = CW'(WMAX);
        else
            w_wr = CW'(cfg_data);

        if (cfg_data == '0)
            h_wr = HW'(1);
        else if (cfg_data > CDW'(HMAX))
            h_wr = HW'(HMAX);
        else
            h_wr = HW'(cfg_data);

        d_wr = (cfg_data[1:0] == 2'd3) ? bmprpd_pkg::SRC_24BPP : cfg_data[1:0];

        width_next     = (cfg_we && cfg_index == bmprpd_pkg::CFG_WIDTH)  ? w_wr : width_reg;
        height_next    = (cfg_we && cfg_index == bmprpd_pkg::CFG_HEIGHT) ? h_wr : height_reg;
        depth_next     = (cfg_we && cfg_index == bmprpd_pkg::CFG_SRC)    ? d_wr : depth_reg;
        out_depth_next = (cfg_we && cfg_index == bmprpd_pkg::CFG_OUT)
                         ? cfg_data[1:0] : out_depth_reg;

        unique case (depth_next)
            bmprpd_pkg::SRC_24BPP: data_bytes_next = (BW'(width_next) << 1) + BW'(width_next);
            bmprpd_pkg::SRC_8BPP:  data_bytes_next = BW'(width_next);
            default:               data_bytes_next = (BW'(width_next) + BW'(1)) >> 1;
        endcase
        row_size_next = (data_bytes_next + BW'(3)) & ~BW'(3);
    end

    assign in_data   = row_byte_reg < data_bytes_reg;
    assign rows_last = (rows_reg + HW'(1)) == height_reg;
    assign col1      = col_reg + CW'(1);
    assign last0     = (col1 == width_reg) && rows_last;
    assign has_low   = col1 < width_reg;
    assign last1     = ((col1 + CW'(1)) == width_reg) && rows_last;
    assign y_cur     = 12'(height_reg - HW'(1) - rows_reg);
    assign rb1       = row_byte_reg + BW'(1);

    always_comb
    begin
        row_byte_next   = row_byte_reg;
        col_next        = col_reg;
        rows_next       = rows_reg;
        partial_next    = partial_reg;
        phase_next      = phase_reg;
        pend_valid_next = pend_valid_reg;
        pend_op_next    = pend_op_reg;
        push_new        = 1'b0;

        new_op.kind   = bmprpd_pkg::OP_PIX_PAL;
        new_op.x      = 12'(col_reg);
        new_op.y      = y_cur;
        new_op.last   = last0;
        new_op.idx    = req.data_byte;
        new_op.colour = req.palette_value;

        if (pend_valid_reg && op_ready)
            pend_valid_next = 1'b0;

        if (cfg_we)
        begin
            row_byte_next = '0;
            col_next      = '0;
            rows_next     = '0;
            partial_next  = '0;
            phase_next    = PH_BLUE;
        end
        else if (accept)
        begin
            if (req.req_type == bmprpd_pkg::REQ_PALETTE)
            begin
                push_new    = 1'b1;
                new_op.kind = bmprpd_pkg::OP_PAL_WRITE;
                new_op.idx  = req.palette_index;
            end
            else
            begin
                if (in_data)
                begin
                    unique case (depth_reg)
                        bmprpd_pkg::SRC_24BPP:
                        begin
                            priority if (phase_reg == PH_BLUE)
                            begin
                                partial_next = {8'h00, req.data_byte};
                                phase_next   = PH_GREEN;
                            end
                            else if (phase_reg == PH_GREEN)
                            begin
                                partial_next = {req.data_byte, partial_reg[7:0]};
                                phase_next   = PH_RED;
                            end
                            else
                            begin
                                push_new      = 1'b1;
                                new_op.kind   = bmprpd_pkg::OP_PIX_RGB;
                                new_op.colour = {req.data_byte, partial_reg};
                                partial_next  = '0;
                                phase_next    = PH_BLUE;
                                col_next      = col1;
                            end
                        end
                        bmprpd_pkg::SRC_8BPP:
                        begin
                            push_new = 1'b1;
                            col_next = col1;
                        end
                        default:
                        begin
                            push_new   = 1'b1;
                            new_op.idx = {4'h0, req.data_byte[7:4]};
                            col_next   = col1;
                            if (has_low)
                            begin
                                pend_valid_next     = 1'b1;
                                pend_op_next.kind   = bmprpd_pkg::OP_PIX_PAL;
                                pend_op_next.x      = 12'(col1);
                                pend_op_next.y      = y_cur;
                                pend_op_next.last   = last1;
                                pend_op_next.idx    = {4'h0, req.data_byte[3:0]};
                                pend_op_next.colour = '0;
                                col_next            = col1 + CW'(1);
                            end
                        end
                    endcase
                end

                if (rb1 >= row_size_reg)
                begin
                    row_byte_next = '0;
                    col_next      = '0;
                    partial_next  = '0;
                    phase_next    = PH_BLUE;
                    rows_next     = rows_last ? '0 : rows_reg + HW'(1);
                end
                else
                begin
                    row_byte_next = rb1;
                end
            end
        end
    end

    assign op_valid = pend_valid_reg || push_new;
    assign op       = pend_valid_reg ? pend_op_reg : new_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= CW'(1);
            height_reg     <= HW'(1);
            depth_reg      <= bmprpd_pkg::SRC_24BPP;
            out_depth_reg  <= bmprpd_pkg::OUT_888;
            data_bytes_reg <= BW'(3);
            row_size_reg   <= BW'(4);
            row_byte_reg   <= '0;
            col_reg        <= '0;
            rows_reg       <= '0;
            partial_reg    <= '0;
            phase_reg      <= PH_BLUE;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            depth_reg      <= depth_next;
            out_depth_reg  <= out_depth_next;
            data_bytes_reg <= data_bytes_next;
            row_size_reg   <= row_size_next;
            row_byte_reg   <= row_byte_next;
            col_reg        <= col_next;
            rows_reg       <= rows_next;
            partial_reg    <= partial_next;
            phase_reg      <= phase_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_op_reg <= pend_op_next;
    end

endmodule

// ===== rtl/bmprpd_fifo.sv =====
// bmprpd_fifo: small op queue between front and back of the decoder.
// Depends on bmprpd_pkg (op_t, QUEUE_DEPTH).
module bmprpd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  bmprpd_pkg::op_t push_data,
    output logic            push_ready,
    output logic            pop_valid,
    output bmprpd_pkg::op_t pop_data,
    input  logic            pop_ready
);

    localparam int QD  = bmprpd_pkg::QUEUE_DEPTH;
    localparam int QAW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);

    bmprpd_pkg::op_t entry_reg [QD];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]  count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = count_reg != QCW'(QD);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ((wr_ptr_reg == QAW'(QD - 1)) ? '0 : wr_ptr_reg + QAW'(1))
                              : wr_ptr_reg;
        rd_ptr_next = do_pop ? ((rd_ptr_reg == QAW'(QD - 1)) ? '0 : rd_ptr_reg + QAW'(1))
                             : rd_ptr_reg;
        count_next  = count_reg + QCW'(do_push) - QCW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/bmprpd_back.sv =====
// bmprpd_back: palette memory, lookup stage, colour conversion and output register.
// Depends on bmprpd_pkg, bmprpd_if.
module bmprpd_back #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    input  bmprpd_pkg::op_t     op,
    output logic                op_ready,
    input  logic [1:0]          out_depth,
    bmprpd_pix_if.source        pix
);

    localparam int PAW = $clog2(PALETTE_DEPTH);
    localparam int IW  = bmprpd_pkg::IDX_W;

    logic [bmprpd_pkg::COLOUR_W-1:0] pal_mem [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0]        pal_valid_reg;

    logic                            s1_valid_reg;
    bmprpd_pkg::op_t                 s1_op_reg;
    logic [bmprpd_pkg::COLOUR_W-1:0] s1_rdata_reg;
    logic                            s1_hit_reg;

    logic                            out_valid_reg;
    logic [bmprpd_pkg::COORD_W-1:0]  out_x_reg;
    logic [bmprpd_pkg::COORD_W-1:0]  out_y_reg;
    logic [bmprpd_pkg::COLOUR_W-1:0] out_value_reg;
    logic                            out_last_reg;

    logic                            free_out;
    logic                            s1_adv;
    logic                            pop;
    logic                            in_range;
    logic [PAW-1:0]                  addr;
    logic [bmprpd_pkg::COLOUR_W-1:0] s1_colour;

    assign free_out = !out_valid_reg || pix.ready;
    assign s1_adv   = s1_valid_reg && free_out;
    assign op_ready = !s1_valid_reg || free_out;
    assign pop      = op_valid && op_ready;
    assign in_range = {1'b0, op.idx} < (IW + 1)'(PALETTE_DEPTH);
    assign addr     = op.idx[PAW-1:0];

    always_comb
    begin
        unique case (s1_op_reg.kind)
            bmprpd_pkg::OP_PIX_RGB: s1_colour = s1_op_reg.colour;
            default:                s1_colour = s1_hit_reg ? s1_rdata_reg : '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop && op.kind == bmprpd_pkg::OP_PAL_WRITE && in_range)
            pal_mem[addr] <= op.colour;
        if (pop)
        begin
            s1_rdata_reg <= pal_mem[addr];
            s1_op_reg    <= op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s1_hit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && op.kind == bmprpd_pkg::OP_PAL_WRITE && in_range)
                pal_valid_reg[addr] <= 1'b1;
            if (pop)
                s1_hit_reg <= in_range && pal_valid_reg[addr];
            if (op_ready)
                s1_valid_reg <= pop && op.kind != bmprpd_pkg::OP_PAL_WRITE;
            if (free_out)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_x_reg     <= s1_op_reg.x;
            out_y_reg     <= s1_op_reg.y;
            out_last_reg  <= s1_op_reg.last;
            out_value_reg <= bmprpd_pkg::convert_colour(out_depth, s1_colour);
        end
    end

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_x     = out_x_reg;
    assign pix.pixel_y     = out_y_reg;
    assign pix.pixel_value = out_value_reg;
    assign pix.last_pixel  = out_last_reg;

endmodule

// ===== rtl/bmp_row_pixel_decoder.sv =====
// bmp_row_pixel_decoder: top level; front classifier, op queue, palette back end.
// Depends on bmprpd_pkg, bmprpd_if, bmprpd_front, bmprpd_fifo, bmprpd_back.
//
//  port   dir   payload                                              protocol
//  req    in    req_type, palette_index, palette_value, data_byte    valid/ready
//  pix    out   pixel_x, pixel_y, pixel_value, last_pixel            valid/ready
//  cfg    in    cfg_index, cfg_data                                  cfg_we strobe
//
// Palette writes, 8-bit and 24-bit bytes: one word per cycle while the op queue has room. A 4-bit byte
// that yields two pixels holds off the next word until its second pixel op, kept in the front's pending
// register, is taken. Each result passes through the op queue, the lookup stage and the output register.
// Reset: palette valid bits clear at once, no sweep; config returns to 1x1, 24-bit in/out.
// A 4-entry op queue lets the input keep flowing while pix is stalled.
module bmp_row_pixel_decoder #(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    bmprpd_req_if.sink                          req,
    bmprpd_pix_if.source                        pix,
    input  logic                                cfg_we,
    input  logic [bmprpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bmprpd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic            f_valid;
    logic            f_ready;
    bmprpd_pkg::op_t f_op;
    logic            q_valid;
    logic            q_ready;
    bmprpd_pkg::op_t q_op;
    logic [1:0]      out_depth;

    bmprpd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_valid  (f_valid),
        .op        (f_op),
        .op_ready  (f_ready),
        .out_depth (out_depth)
    );

    bmprpd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_data  (f_op),
        .push_ready (f_ready),
        .pop_valid  (q_valid),
        .pop_data   (q_op),
        .pop_ready  (q_ready)
    );

    bmprpd_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (q_valid),
        .op        (q_op),
        .op_ready  (q_ready),
        .out_depth (out_depth),
        .pix       (pix)
    );

endmodule

// ===== rtl/bmprpd_checker.sv =====
// bmprpd_checker: port-level assertions for bmp_row_pixel_decoder, bound to the top.
// Depends on bmprpd_pkg for widths.
module bmprpd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             pix_valid,
    input logic                             pix_ready,
    input logic [bmprpd_pkg::COORD_W-1:0]   pix_x,
    input logic [bmprpd_pkg::COORD_W-1:0]   pix_y,
    input logic [bmprpd_pkg::COLOUR_W-1:0]  pix_value,
    input logic                             pix_last
);

    // stalled result word must hold
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid && $stable(pix_x) && $stable(pix_y)
                                    && $stable(pix_value) && $stable(pix_last))
        else $error("pix word changed while stalled");

    // last pixel of image lies on the top row (rows arrive bottom first)
    a_last_top_row: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_last |-> pix_y == '0)
        else $error("last_pixel flagged off row zero");

    // nothing is presented straight out of reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !pix_valid)
        else $error("pix valid right after reset");

endmodule

bind bmp_row_pixel_decoder bmprpd_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix.valid),
    .pix_ready (pix.ready),
    .pix_x     (pix.pixel_x),
    .pix_y     (pix.pixel_y),
    .pix_value (pix.pixel_value),
    .pix_last  (pix.last_pixel)
);

// ===== sim/bmp_row_pixel_decoder_tb.sv =====
// bmp_row_pixel_decoder_tb: self-checking bench for the BMP row pixel decoder.
// Needs bmprpd_pkg, bmprpd_req_if / bmprpd_pix_if and the decoder RTL; a local
// decode model predicts every pixel word and a monitor checks them in order.
module bmp_row_pixel_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_DIM    = 4096;
    localparam logic [1:0]  SRC_UNUSED = 2'd3;
    localparam int unsigned RANDOM_WORDS = 520;

    typedef struct packed {
        logic [bmprpd_pkg::COORD_W-1:0]  px;
        logic [bmprpd_pkg::COORD_W-1:0]  py;
        logic [bmprpd_pkg::COLOUR_W-1:0] colour;
        logic                            is_last;
    } pixel_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [bmprpd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bmprpd_pkg::CFG_DATA_W-1:0] cfg_data;

    bmprpd_req_if req();
    bmprpd_pix_if pix();

    bmp_row_pixel_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .pix       (pix),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // decode model state
    logic [bmprpd_pkg::COLOUR_W-1:0] palette [256];
    logic [13:0]           row_pos;
    logic [12:0]           col_pos;
    logic [12:0]           rows_seen;
    logic [15:0]           colour_acc;
    logic [1:0]            byte_idx;
    logic [12:0]           cfg_width;
    logic [12:0]           cfg_height;
    logic [1:0]            cfg_src;
    logic [1:0]            cfg_out;

    pixel_t                due_pixels [$];
    int unsigned           mismatches;
    int unsigned           words_sent;
    bit                    source_gaps;
    bit                    sink_stalls;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(10_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int unsigned effective_size(logic [12:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    function automatic int unsigned row_bytes(logic [12:0] w13, logic [1:0] src);
        int unsigned w;
        int unsigned n;
        w = effective_size(w13);
        if (src == bmprpd_pkg::SRC_4BPP)
            n = (w + 1) / 2;
        else if (src == bmprpd_pkg::SRC_8BPP)
            n = w;
        else
            n = 3 * w;
        return (n + 3) / 4 * 4;
    endfunction

    function automatic logic [bmprpd_pkg::COLOUR_W-1:0] format_colour(
        logic [1:0] mode, logic [bmprpd_pkg::COLOUR_W-1:0] rgb);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        r = rgb >> 16;
        g = (rgb >> 8) & 255;
        b = rgb & 255;
        case (mode)
            bmprpd_pkg::OUT_332: return 24'((r >> 5) | ((g >> 5) << 3) | ((b >> 6) << 6));
            bmprpd_pkg::OUT_555: return 24'(((r >> 3) << 10) | ((g >> 3) << 5) | (b >> 3));
            bmprpd_pkg::OUT_565: return 24'(((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3));
            default: return rgb;
        endcase
    endfunction

    function automatic void restart_counters();
        row_pos    = '0;
        col_pos    = '0;
        rows_seen  = '0;
        colour_acc = '0;
        byte_idx   = '0;
    endfunction

    function automatic void push_pixel(logic [bmprpd_pkg::COLOUR_W-1:0] rgb,
                                       int unsigned w, int unsigned h);
        pixel_t p;
        p.px      = col_pos[bmprpd_pkg::COORD_W-1:0];
        p.py      = 12'(h - 1 - rows_seen);
        p.colour  = format_colour(cfg_out, rgb);
        p.is_last = (col_pos + 1 == w) && (rows_seen + 1 == h);
        due_pixels.push_back(p);
        col_pos++;
    endfunction

    function automatic void decode_word(logic kind, logic [bmprpd_pkg::IDX_W-1:0] pidx,
                                        logic [bmprpd_pkg::COLOUR_W-1:0] pval,
                                        logic [bmprpd_pkg::BYTE_W-1:0] db);
        int unsigned w;
        int unsigned h;
        int unsigned data_len;
        if (kind == bmprpd_pkg::REQ_PALETTE)
        begin
            palette[pidx] = pval;
            return;
        end
        w = effective_size(cfg_width);
        h = effective_size(cfg_height);
        if (cfg_src == bmprpd_pkg::SRC_4BPP)
            data_len = (w + 1) / 2;
        else if (cfg_src == bmprpd_pkg::SRC_8BPP)
            data_len = w;
        else
            data_len = 3 * w;
        if (row_pos < data_len)
        begin
            if (cfg_src == bmprpd_pkg::SRC_4BPP)
            begin
                push_pixel(palette[db[7:4]], w, h);
                // low nibble dropped once the row is full
                if (col_pos < w)
                    push_pixel(palette[db[3:0]], w, h);
            end
            else if (cfg_src == bmprpd_pkg::SRC_8BPP)
            begin
                push_pixel(palette[db], w, h);
            end
            else if (byte_idx == 0)
            begin
                colour_acc = {8'h00, db};
                byte_idx   = 1;
            end
            else if (byte_idx == 1)
            begin
                colour_acc[15:8] = db;
                byte_idx         = 2;
            end
            else
            begin
                push_pixel({db, colour_acc}, w, h);
                colour_acc = '0;
                byte_idx   = '0;
            end
        end
        row_pos++;
        if (row_pos >= row_bytes(cfg_width, cfg_src))
        begin
            row_pos    = '0;
            col_pos    = '0;
            colour_acc = '0;
            byte_idx   = '0;
            rows_seen++;
            if (rows_seen >= h)
                rows_seen = '0;
        end
    endfunction

    // pixel sink: random ready stalls
    initial
    begin : pixel_sink
        int hold;
        hold = 0;
        pix.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold == 0 && sink_stalls && $urandom_range(0, 9) == 0)
                hold = $urandom_range(1, 11);
            if (hold > 0)
            begin
                pix.ready <= 1'b0;
                hold--;
            end
            else
            begin
                pix.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : pixel_check
        pixel_t want;
        if (rst_n && pix.valid && pix.ready)
        begin
            if (due_pixels.size() == 0)
            begin
                $error("unexpected pixel word x=%0d y=%0d value=%h last=%b",
                       pix.pixel_x, pix.pixel_y, pix.pixel_value, pix.last_pixel);
                mismatches++;
            end
            else
            begin
                want = due_pixels.pop_front();
                if (pix.pixel_x !== want.px)
                begin
                    $error("pixel_x expected %0d got %0d", want.px, pix.pixel_x);
                    mismatches++;
                end
                if (pix.pixel_y !== want.py)
                begin
                    $error("pixel_y expected %0d got %0d", want.py, pix.pixel_y);
                    mismatches++;
                end
                if (pix.pixel_value !== want.colour)
                begin
                    $error("pixel_value expected %h got %h", want.colour, pix.pixel_value);
                    mismatches++;
                end
                if (pix.last_pixel !== want.is_last)
                begin
                    $error("last_pixel expected %b got %b", want.is_last, pix.last_pixel);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_word(logic kind, logic [bmprpd_pkg::IDX_W-1:0] pidx,
                             logic [bmprpd_pkg::COLOUR_W-1:0] pval,
                             logic [bmprpd_pkg::BYTE_W-1:0] db);
        if (source_gaps && $urandom_range(0, 5) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.req_type      <= kind;
        req.palette_index <= pidx;
        req.palette_value <= pval;
        req.data_byte     <= db;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        decode_word(kind, pidx, pval, db);
        words_sent++;
    endtask

    task automatic send_palette(logic [bmprpd_pkg::IDX_W-1:0] pidx,
                                logic [bmprpd_pkg::COLOUR_W-1:0] pval);
        send_word(bmprpd_pkg::REQ_PALETTE, pidx, pval, 8'($urandom));
    endtask

    task automatic send_byte(logic [bmprpd_pkg::BYTE_W-1:0] db);
        send_word(bmprpd_pkg::REQ_PIXEL, 8'($urandom), 24'($urandom), db);
    endtask

    // stop sending, let every expected pixel arrive, then let no-result words retire
    task automatic wait_drain();
        req.valid <= 1'b0;
        while (due_pixels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [bmprpd_pkg::CFG_IDX_W-1:0] idx,
                             logic [bmprpd_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            bmprpd_pkg::CFG_WIDTH:  cfg_width  = val;
            bmprpd_pkg::CFG_HEIGHT: cfg_height = val;
            bmprpd_pkg::CFG_SRC:    cfg_src    = val[1:0];
            default:                cfg_out    = val[1:0];
        endcase
        restart_counters();
    endtask

    task automatic set_image(logic [12:0] w, logic [12:0] h, logic [1:0] src,
                             logic [1:0] fmt);
        write_reg(bmprpd_pkg::CFG_WIDTH, w);
        write_reg(bmprpd_pkg::CFG_HEIGHT, h);
        write_reg(bmprpd_pkg::CFG_SRC, {11'($urandom), src});
        write_reg(bmprpd_pkg::CFG_OUT, {11'($urandom), fmt});
    endtask

    // reset config: 1x1, 24-bit in and out
    task automatic test_default_config();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h5A);
    endtask

    // odd width: second nibble of the last byte falls past the row
    task automatic test_nibble_palette();
        wait_drain();
        set_image(13'd3, 13'd1, bmprpd_pkg::SRC_4BPP, bmprpd_pkg::OUT_565);
        send_palette(8'd0, 24'hFFFFFF);
        send_palette(8'd15, 24'h123456);
        send_byte(8'hF0);
        send_byte(8'h0F);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    // zero width acts as one, oversize height clamps; unwritten entry reads zero
    task automatic test_clamped_sizes();
        wait_drain();
        set_image(13'd0, 13'd8191, bmprpd_pkg::SRC_8BPP, bmprpd_pkg::OUT_332);
        repeat (4) send_byte(8'hFF);
        send_palette(8'd255, 24'h000000);
        send_palette(8'd255, 24'hE0E0C0);
        send_byte(8'hFF);
        repeat (2) send_byte(8'($urandom));
    endtask

    task automatic test_unused_depth();
        wait_drain();
        set_image(13'd1, 13'd1, SRC_UNUSED, bmprpd_pkg::OUT_555);
        send_byte(8'h0F);
        send_byte(8'hF0);
        send_byte(8'hA5);
        send_byte(8'h3C);
    endtask

    // opening bytes of a row at the clamped largest width
    task automatic test_wide_row();
        int unsigned i;
        wait_drain();
        set_image(13'd8191, 13'd4096, bmprpd_pkg::SRC_4BPP, 2'($urandom));
        for (i = 0; i < 16; i++)
            send_palette(8'(i), 24'($urandom));
        repeat (64) send_byte(8'($urandom));
    endtask

    task automatic test_random_images();
        int unsigned first;
        int unsigned w;
        int unsigned count;
        int unsigned i;
        logic [1:0]  src;
        logic [1:0]  fmt;
        first = words_sent;
        while (words_sent - first < RANDOM_WORDS)
        begin
            wait_drain();
            source_gaps = $urandom_range(0, 3) != 0;
            sink_stalls = $urandom_range(0, 3) != 0;
            src = 2'($urandom);
            fmt = 2'($urandom);
            if (words_sent != first && $urandom_range(0, 4) == 0)
            begin
                write_reg(bmprpd_pkg::CFG_OUT, {11'($urandom), fmt});
            end
            else
            begin
                if ($urandom_range(0, 15) == 0)
                    w = $urandom_range(4097, 8191);
                else if ($urandom_range(0, 3) == 0)
                    w = $urandom_range(0, 4);
                else
                    w = $urandom_range(1, 24);
                set_image(13'(w), 13'($urandom_range(0, 4)), src, fmt);
            end
            if (cfg_src == bmprpd_pkg::SRC_4BPP || cfg_src == bmprpd_pkg::SRC_8BPP)
            begin
                repeat ($urandom_range(0, 16))
                    send_palette(cfg_src == bmprpd_pkg::SRC_4BPP
                                 ? 8'($urandom_range(0, 15)) : 8'($urandom),
                                 24'($urandom));
            end
            count = row_bytes(cfg_width, cfg_src) * effective_size(cfg_height)
                    * $urandom_range(1, 2);
            if (effective_size(cfg_width) > 64)
                count = $urandom_range(1, 60);
            if ($urandom_range(0, 4) == 0)
                count = $urandom_range(0, count);
            for (i = 0; i < count; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_palette(8'($urandom), 24'($urandom));
                if ($urandom_range(0, 99) == 0)
                    wait_drain();
                send_byte(8'($urandom));
            end
        end
    endtask

    // back-to-back at full rate, no stalls on either side
    task automatic test_steady_stream();
        int unsigned i;
        wait_drain();
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        set_image(13'd16, 13'd2, bmprpd_pkg::SRC_4BPP, 2'($urandom));
        for (i = 0; i < 16; i++)
            send_palette(8'(i), 24'($urandom));
        repeat (3 * row_bytes(cfg_width, cfg_src) * 2) send_byte(8'($urandom));
        wait_drain();
        set_image(13'd5, 13'd2, bmprpd_pkg::SRC_24BPP, bmprpd_pkg::OUT_888);
        repeat (row_bytes(cfg_width, cfg_src) * 2) send_byte(8'($urandom));
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        req.valid         = 1'b0;
        req.req_type      = bmprpd_pkg::REQ_PIXEL;
        req.palette_index = '0;
        req.palette_value = '0;
        req.data_byte     = '0;
        mismatches        = 0;
        words_sent        = 0;
        source_gaps       = 1'b1;
        sink_stalls       = 1'b1;
        for (int i = 0; i < 256; i++)
            palette[i] = '0;
        cfg_width  = 13'd1;
        cfg_height = 13'd1;
        cfg_src    = bmprpd_pkg::SRC_24BPP;
        cfg_out    = bmprpd_pkg::OUT_888;
        restart_counters();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_default_config();
        test_nibble_palette();
        test_clamped_sizes();
        test_unused_depth();
        test_wide_row();
        test_random_images();
        test_steady_stream();

        req.valid <= 1'b0;
        while (due_pixels.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
